// ----- rtl/rlcc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the registered logic consistency checker.
package rlcc_pkg;

  localparam logic [7:0] ALL_ONES = 8'hFF;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ENTRY_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_ONES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_ZEROS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_ONES     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_ZEROS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_INVERT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COMB_OUT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COMB_FB      = 3'd6;

  typedef struct packed {
    logic       func;
    logic [7:0] pin_inputs;
    logic [7:0] pin_outputs;
    logic       clock_edge;
  } rlcc_in_t;

  typedef struct packed {
    logic       consistent;
    logic [7:0] register_value;
    logic [7:0] register_known;
  } rlcc_out_t;

  // What a sample does to the kept register image before the merge.
  typedef enum logic [1:0] {
    ACT_KEEP,
    ACT_CLEAR,
    ACT_SET,
    ACT_DROP
  } reg_action_t;

  typedef struct packed {
    logic        func;
    reg_action_t action;
    logic [7:0]  inp;
    logic [7:0]  obs;
    logic [7:0]  qk;
    logic [7:0]  dk;
    logic [7:0]  fb_mask;
  } rlcc_cls_t;

  // Head of the queue between front and back.
  typedef struct packed {
    logic      empty;
    rlcc_cls_t item;
  } cls_head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_SWEEP
  } back_state_t;

endpackage

// ----- rtl/registered_logic_consistency_checker.sv -----
`timescale 1ns / 1ps
// Top level of the registered logic consistency checker.
//
//   channel  direction  handshake                  payload
//   in_      input      in_push / in_full          rlcc_in_t  (func, pins, clock_edge)
//   out_     output     out_pop / out_empty        rlcc_out_t (consistent, register image)
//   cfg_     input      cfg_we, cfg_index          cfg_data, 8 bits, no read-back
//
// A check is answered from the back end's idle state, or from the merge state when the table entry is
// read and written back through the table RAM's separate read and write ports.
// A clear (func=1) is answered at once and then sweeps the 65536-entry table,
// one entry a cycle; the next item waits for the sweep to finish.
// After reset the same sweep runs with in_full held high.
// Two-entry queues before and after the back end let either side stall alone.
module registered_logic_consistency_checker
  import rlcc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 65536
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_push,
  input  rlcc_in_t             in_data,
  output logic                 in_full,
  input  logic                 out_pop,
  output rlcc_out_t            out_data,
  output logic                 out_empty
);

  cls_head_t  q_head;
  logic       q_full, q_pop;
  logic       res_full, res_push, init_busy;
  rlcc_out_t  res_data;
  logic [$bits(rlcc_out_t)-1:0] out_bits;

  // Hold off input while the table is swept after reset
  assign in_full = q_full || init_busy;

  rlcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push && !init_busy),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_pop     (q_pop),
    .q_head    (q_head)
  );

  rlcc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data),
    .init_busy (init_busy)
  );

  rlcc_fifo #(
    .WIDTH ($bits(rlcc_out_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_bits),
    .empty (out_empty)
  );

  assign out_data = rlcc_out_t'(out_bits);

endmodule

// ----- rtl/rlcc_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module rlcc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rlcc_fifo.sv -----
`timescale 1ns / 1ps
// Small synchronous queue used between the front, the back and the result port.
module rlcc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/rlcc_front.sv -----
`timescale 1ns / 1ps
// Front end: configuration registers, sample classification and the queue to the back end.
module rlcc_front
  import rlcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_push,
  input  rlcc_in_t             in_data,
  output logic                 q_full,
  input  logic                 q_pop,
  output cls_head_t            q_head
);

  logic [7:0] clear_ones_r, clear_zeros_r, set_ones_r, set_zeros_r;
  logic [7:0] out_invert_r, comb_out_r, comb_fb_r;
  logic       is_clr, is_set, plain_edge;
  rlcc_cls_t  cls;
  logic [$bits(rlcc_cls_t)-1:0] head_bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_ones_r  <= '0;
      clear_zeros_r <= '0;
      set_ones_r    <= '0;
      set_zeros_r   <= '0;
      out_invert_r  <= '0;
      comb_out_r    <= '0;
      comb_fb_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLEAR_ONES:  clear_ones_r  <= cfg_data;
        CFG_CLEAR_ZEROS: clear_zeros_r <= cfg_data;
        CFG_SET_ONES:    set_ones_r    <= cfg_data;
        CFG_SET_ZEROS:   set_zeros_r   <= cfg_data;
        CFG_OUT_INVERT:  out_invert_r  <= cfg_data;
        CFG_COMB_OUT:    comb_out_r    <= cfg_data;
        CFG_COMB_FB:     comb_fb_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign is_clr = ((in_data.pin_inputs & clear_ones_r) == clear_ones_r) &&
                  ((~in_data.pin_inputs & clear_zeros_r) == clear_zeros_r);
  assign is_set = ((in_data.pin_inputs & set_ones_r) == set_ones_r) &&
                  ((~in_data.pin_inputs & set_zeros_r) == set_zeros_r);
  // An edge without clear or set makes every observed output bit known
  assign plain_edge = !is_clr && !is_set && in_data.clock_edge;

  always_comb begin
    cls.func    = in_data.func;
    cls.inp     = in_data.pin_inputs;
    cls.obs     = in_data.pin_outputs ^ out_invert_r;
    cls.qk      = plain_edge ? ALL_ONES : ~comb_out_r;
    cls.dk      = plain_edge ? ALL_ONES : comb_out_r;
    cls.fb_mask = comb_fb_r;
    priority if (is_clr) begin
      cls.action = ACT_CLEAR;
    end else if (in_data.clock_edge && is_set) begin
      cls.action = ACT_SET;
    end else if (in_data.clock_edge) begin
      cls.action = ACT_DROP;
    end else begin
      cls.action = ACT_KEEP;
    end
  end

  rlcc_fifo #(
    .WIDTH ($bits(rlcc_cls_t)),
    .DEPTH (2)
  ) u_cls_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cls),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (head_bits),
    .empty (q_head.empty)
  );

  assign q_head.item = rlcc_cls_t'(head_bits);

endmodule

// ----- rtl/rlcc_back.sv -----
`timescale 1ns / 1ps
// Back end: register image update, table read-modify-write and table clearing sweep.
module rlcc_back
  import rlcc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 65536
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cls_head_t q_head,
  output logic      q_pop,
  input  logic      res_full,
  output logic      res_push,
  output rlcc_out_t res_data,
  output logic      init_busy
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

  back_state_t   state_r, state_nxt;
  logic [7:0]    reg_value_r, reg_value_nxt;
  logic [7:0]    reg_known_r, reg_known_nxt;
  logic [7:0]    dv_r, dv_nxt;
  logic [7:0]    dk_r, dk_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          init_r, init_nxt;

  rlcc_cls_t        h;
  logic             go;
  logic [7:0]       rv1, rk1, rv2, rk2, fbv, fbk;
  logic             reg_conflict, need_table;
  logic [15:0]      tab_idx;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [7:0]       ev, ek;
  logic             tab_conflict;

  assign h  = q_head.item;
  assign go = (state_r == ST_IDLE) && !q_head.empty && !res_full;
  assign init_busy = init_r;

  // Forced or dropped image, then merge with the registered outputs
  always_comb begin
    unique case (h.action)
      ACT_CLEAR: begin rv1 = 8'h00;       rk1 = ALL_ONES;    end
      ACT_SET:   begin rv1 = ALL_ONES;    rk1 = ALL_ONES;    end
      ACT_DROP:  begin rv1 = reg_value_r; rk1 = 8'h00;       end
      default:   begin rv1 = reg_value_r; rk1 = reg_known_r; end
    endcase
  end

  assign reg_conflict = |((rv1 ^ h.obs) & rk1 & h.qk);
  assign rv2 = (rk1 & rv1) | (~rk1 & h.obs);
  assign rk2 = rk1 | h.qk;
  assign fbv = (h.fb_mask & h.obs) | (~h.fb_mask & rv2);
  assign fbk = (h.fb_mask & h.dk) | (~h.fb_mask & rk2);
  assign need_table = !reg_conflict && (fbk == ALL_ONES);
  assign tab_idx = {h.inp, fbv};

  assign ev = ram_rdata[7:0];
  assign ek = ram_rdata[15:8];
  assign tab_conflict = |((dv_r ^ ev) & dk_r & ek);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          if (h.func) begin
            state_nxt = ST_SWEEP;
          end else if (need_table) begin
            state_nxt = ST_MERGE;
          end
        end
      end
      ST_MERGE: state_nxt = ST_IDLE;
      ST_SWEEP: begin
        if (addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    res_push      = 1'b0;
    res_data      = '{consistent: 1'b1, register_value: reg_value_r,
                      register_known: reg_known_r};
    reg_value_nxt = reg_value_r;
    reg_known_nxt = reg_known_r;
    dv_nxt        = dv_r;
    dk_nxt        = dk_r;
    addr_nxt      = addr_r;
    init_nxt      = init_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          q_pop = 1'b1;
          if (h.func) begin
            // Forget the register, answer at once, then sweep the table
            reg_known_nxt           = 8'h00;
            res_push                = 1'b1;
            res_data.register_known = 8'h00;
            addr_nxt                = '0;
          end else if (reg_conflict) begin
            reg_value_nxt = rv1;
            reg_known_nxt = rk1;
            res_push      = 1'b1;
            res_data      = '{consistent: 1'b0, register_value: rv1, register_known: rk1};
          end else begin
            reg_value_nxt = rv2;
            reg_known_nxt = rk2;
            if (need_table) begin
              ram_re   = 1'b1;
              dv_nxt   = h.obs;
              dk_nxt   = h.dk;
              addr_nxt = tab_idx[AW-1:0];
            end else begin
              res_push = 1'b1;
              res_data = '{consistent: 1'b1, register_value: rv2, register_known: rk2};
            end
          end
        end
      end
      ST_MERGE: begin
        res_push            = 1'b1;
        res_data.consistent = !tab_conflict;
        if (!tab_conflict) begin
          ram_we    = 1'b1;
          ram_wdata = {dk_r | ek, (dk_r & dv_r) | (~dk_r & ev)};
        end
      end
      ST_SWEEP: begin
        ram_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_ADDR) begin
          init_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      addr_r      <= '0;
      init_r      <= 1'b1;
      reg_value_r <= '0;
      reg_known_r <= '0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      init_r      <= init_nxt;
      reg_value_r <= reg_value_nxt;
      reg_known_r <= reg_known_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dv_r <= dv_nxt;
    dk_r <= dk_nxt;
  end

  rlcc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (tab_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

endmodule

// ----- rtl/rlcc_checker.sv -----
`timescale 1ns / 1ps
// Port-level assertions for the registered logic consistency checker, with their bind.
module rlcc_checker
  import rlcc_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_full,
  input logic                 out_pop,
  input rlcc_out_t            out_data,
  input logic                 out_empty
);

  // No result may be left over from before a reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // The table sweep after reset must block input
  a_reset_full: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input accepted during table sweep after reset");

  // A waiting result stays until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed or vanished");

endmodule

bind registered_logic_consistency_checker rlcc_checker u_rlcc_checker (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the registered logic consistency checker.
module testbench;
  import rlcc_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CLEAR_ONES;
  logic [7:0]           cfg_data = '0;
  logic                 in_push = 1'b0;
  rlcc_in_t             in_data = '0;
  logic                 in_full;
  logic                 out_pop = 1'b0;
  rlcc_out_t            out_data;
  logic                 out_empty;

  // Predictor state: configuration image, register image and next-state table.
  logic [7:0]  cfg_image [0:6];
  logic [7:0]  reg_image;
  logic [7:0]  reg_known_image;
  logic [15:0] next_state_model [0:65535];
  rlcc_out_t   expected_results [$];

  // Stimulus device: hidden register, its next-state and combinational lookups.
  logic [7:0] dev_reg;
  logic [7:0] dev_next [0:255];
  logic [7:0] dev_comb [0:255];
  logic [7:0] in_pool [0:3];

  int mismatch_count = 0;
  int stall_left = 0;
  int clears_left = 3;
  bit sender_idling = 1'b1;
  bit sink_idling = 1'b1;

  registered_logic_consistency_checker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .out_empty (out_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic mask_hit(logic [7:0] pins, logic [7:0] ones, logic [7:0] zeros);
    return ((pins & ones) == ones) && ((~pins & zeros) == zeros);
  endfunction

  // Work out the result of one sample and advance the register and table image.
  function automatic rlcc_out_t consistency_result(rlcc_in_t item);
    rlcc_out_t  res;
    logic       clr, setr, ok;
    logic [7:0] inp, obs, dv, dk, qk, fbm, fbv, fbk, ev, ek;
    logic [15:0] ix;
    ok = 1'b1;
    if (item.func) begin
      reg_known_image = '0;
      foreach (next_state_model[i]) next_state_model[i] = '0;
    end else begin
      inp  = item.pin_inputs;
      clr  = mask_hit(inp, cfg_image[CFG_CLEAR_ONES], cfg_image[CFG_CLEAR_ZEROS]);
      setr = mask_hit(inp, cfg_image[CFG_SET_ONES], cfg_image[CFG_SET_ZEROS]);
      obs  = item.pin_outputs ^ cfg_image[CFG_OUT_INVERT];
      dv   = obs;
      dk   = cfg_image[CFG_COMB_OUT];
      qk   = ~cfg_image[CFG_COMB_OUT];
      fbm  = cfg_image[CFG_COMB_FB];
      if (!clr && item.clock_edge && !setr) begin
        qk = ALL_ONES;
        dk = ALL_ONES;
      end
      // Clear wins over set; a plain edge drops what was known.
      if (clr) begin
        reg_image       = '0;
        reg_known_image = ALL_ONES;
      end else if (item.clock_edge) begin
        if (setr) begin
          reg_image       = ALL_ONES;
          reg_known_image = ALL_ONES;
        end else begin
          reg_known_image = '0;
        end
      end
      if (((reg_image ^ obs) & reg_known_image & qk) != '0) begin
        ok = 1'b0;
      end else begin
        reg_image       = (reg_known_image & reg_image) | (~reg_known_image & obs);
        reg_known_image = reg_known_image | qk;
        fbv = (fbm & dv) | (~fbm & reg_image);
        fbk = (fbm & dk) | (~fbm & reg_known_image);
        if (fbk == ALL_ONES) begin
          ix = {inp, fbv};
          ev = next_state_model[ix][7:0];
          ek = next_state_model[ix][15:8];
          if (((dv ^ ev) & dk & ek) != '0) begin
            ok = 1'b0;
          end else begin
            dv = (dk & dv) | (~dk & ev);
            dk = dk | ek;
            next_state_model[ix] = {dk, dv};
          end
        end
      end
    end
    res.consistent     = ok;
    res.register_value = reg_image;
    res.register_known = reg_known_image;
    return res;
  endfunction

  // Compare each popped result with the oldest expectation and drive pop.
  always @(posedge clk) begin : result_check
    rlcc_out_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $error("result with no transaction waiting: %h", out_data);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.consistent !== want.consistent) begin
            $error("consistent: expected %0b, got %0b", want.consistent, out_data.consistent);
            mismatch_count++;
          end
          if (out_data.register_value !== want.register_value) begin
            $error("register_value: expected %h, got %h",
                   want.register_value, out_data.register_value);
            mismatch_count++;
          end
          if (out_data.register_known !== want.register_known) begin
            $error("register_known: expected %h, got %h",
                   want.register_known, out_data.register_known);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (sink_idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic send_sample(input rlcc_in_t item);
    in_data <= item;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    expected_results.push_back(consistency_result(item));
    if (sender_idling && $urandom_range(0, 4) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_pins(input logic func, input logic [7:0] inp, input logic [7:0] outp,
                           input logic edge_seen);
    rlcc_in_t item;
    item.func        = func;
    item.pin_inputs  = inp;
    item.pin_outputs = outp;
    item.clock_edge  = edge_seen;
    send_sample(item);
  endtask

  // Drop push, then hold until every result is back.
  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_image[idx] = value;
  endtask

  // Hold the input side quiet and write every register.
  task automatic load_config(input logic [7:0] clr1, input logic [7:0] clr0,
                             input logic [7:0] set1, input logic [7:0] set0,
                             input logic [7:0] inv, input logic [7:0] comb_out,
                             input logic [7:0] comb_fb);
    wait_drained();
    write_register(CFG_CLEAR_ONES, clr1);
    write_register(CFG_CLEAR_ZEROS, clr0);
    write_register(CFG_SET_ONES, set1);
    write_register(CFG_SET_ZEROS, set0);
    write_register(CFG_OUT_INVERT, inv);
    write_register(CFG_COMB_OUT, comb_out);
    write_register(CFG_COMB_FB, comb_fb);
    cfg_we <= 1'b0;
  endtask

  // Zero masks: every sample means clear, so only all-zero observations agree.
  task automatic test_zero_masks();
    load_config('0, '0, '0, '0, '0, '0, '0);
    send_pins(1'b0, 8'h00, 8'h00, 1'b0);
    send_pins(1'b0, ALL_ONES, ALL_ONES, 1'b1);
    send_pins(1'b0, 8'h00, ALL_ONES, 1'b0);
  endtask

  // Clear on bit 0, set on bit 1, upper nibble combinational, feedback from register.
  task automatic test_special_cases();
    load_config(8'h01, 8'h00, 8'h02, 8'h00, 8'hA5, 8'hF0, 8'h00);
    send_pins(1'b0, 8'h00, 8'h5A, 1'b1);  // plain edge, table written
    send_pins(1'b0, 8'h00, 8'h5A, 1'b0);  // agrees with table
    send_pins(1'b0, 8'h00, 8'hDA, 1'b0);  // table conflict
    send_pins(1'b0, 8'h00, 8'h5B, 1'b0);  // register conflict
    send_pins(1'b0, 8'h01, 8'hA5, 1'b0);  // clear without edge
    send_pins(1'b0, 8'h03, 8'h5A, 1'b1);  // clear and set together
    send_pins(1'b0, 8'h02, 8'h5A, 1'b1);  // set
    send_pins(1'b0, 8'h02, 8'h00, 1'b0);  // disagrees with set image
    send_pins(1'b1, 8'h00, 8'h00, 1'b0);  // clear knowledge and table
    send_pins(1'b0, ALL_ONES, ALL_ONES, 1'b1);
    send_pins(1'b0, 8'h00, 8'h5A, 1'b0);
  endtask

  // Full masks: clear impossible, set only on all-ones inputs, everything combinational.
  task automatic test_full_masks();
    load_config(ALL_ONES, ALL_ONES, ALL_ONES, '0, ALL_ONES, ALL_ONES, ALL_ONES);
    send_pins(1'b0, ALL_ONES, 8'h00, 1'b1);
    send_pins(1'b0, ALL_ONES, 8'h00, 1'b0);
    send_pins(1'b0, 8'h00, 8'h00, 1'b1);
    send_pins(1'b0, 8'h00, 8'h0F, 1'b0);
    send_pins(1'b0, 8'h80, ALL_ONES, 1'b1);
  endtask

  function automatic logic [7:0] sparse_byte();
    return 8'($urandom & $urandom & $urandom);
  endfunction

  // Next sample of the stimulus device, now and then with one output bit broken.
  function automatic rlcc_in_t device_sample();
    rlcc_in_t   s;
    logic [7:0] cm;
    s.func       = 1'b0;
    s.pin_inputs = in_pool[$urandom_range(0, 3)];
    s.clock_edge = 1'($urandom_range(0, 1));
    if (mask_hit(s.pin_inputs, cfg_image[CFG_CLEAR_ONES], cfg_image[CFG_CLEAR_ZEROS])) begin
      dev_reg = '0;
    end else if (s.clock_edge) begin
      if (mask_hit(s.pin_inputs, cfg_image[CFG_SET_ONES], cfg_image[CFG_SET_ZEROS]))
        dev_reg = ALL_ONES;
      else
        dev_reg = dev_next[s.pin_inputs ^ dev_reg];
    end
    cm = cfg_image[CFG_COMB_OUT];
    s.pin_outputs = ((dev_reg & ~cm) | (dev_comb[s.pin_inputs] & cm)) ^ cfg_image[CFG_OUT_INVERT];
    if ($urandom_range(0, 9) == 0) s.pin_outputs ^= 8'h01 << $urandom_range(0, 7);
    return s;
  endfunction

  task automatic test_random_phase(input int n_items, input bit idle, input bit pressure);
    logic [7:0] clr1, set1;
    rlcc_in_t   item;
    clr1 = sparse_byte() | (8'h01 << $urandom_range(0, 7));
    set1 = sparse_byte() | (8'h01 << $urandom_range(0, 7));
    load_config(clr1, sparse_byte() & ~clr1, set1, sparse_byte() & ~set1,
                8'($urandom), 8'($urandom), 8'($urandom));
    sender_idling = idle;
    sink_idling   = idle;
    foreach (dev_next[i]) dev_next[i] = 8'($urandom);
    foreach (dev_comb[i]) dev_comb[i] = 8'($urandom);
    dev_reg    = 8'($urandom);
    in_pool[0] = 8'($urandom);
    in_pool[1] = (8'($urandom) & ~cfg_image[CFG_CLEAR_ZEROS]) | cfg_image[CFG_CLEAR_ONES];
    in_pool[2] = (8'($urandom) & ~cfg_image[CFG_SET_ZEROS]) | cfg_image[CFG_SET_ONES];
    in_pool[3] = 8'($urandom) & ~cfg_image[CFG_CLEAR_ONES];
    for (int n = 0; n < n_items; n++) begin
      if (pressure && n == n_items / 2) wait_drained();
      if (clears_left > 0 && $urandom_range(0, 99) == 0) begin
        clears_left--;
        item = {1'b1, 8'($urandom), 8'($urandom), 1'($urandom)};
      end else if ($urandom_range(0, 5) == 0) begin
        item = {1'b0, 8'($urandom), 8'($urandom), 1'($urandom)};
      end else begin
        item = device_sample();
      end
      send_sample(item);
    end
  endtask

  initial begin
    foreach (cfg_image[i]) cfg_image[i] = '0;
    foreach (next_state_model[i]) next_state_model[i] = '0;
    reg_image       = '0;
    reg_known_image = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_zero_masks();
    test_special_cases();
    test_full_masks();
    test_random_phase(125, 1'b1, 1'b0);
    test_random_phase(125, 1'b1, 1'b1);
    test_random_phase(125, 1'b1, 1'b0);
    test_random_phase(125, 1'b0, 1'b0);
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rlcc_pkg.sv
rtl/rlcc_ram.sv
rtl/rlcc_fifo.sv
rtl/rlcc_front.sv
rtl/rlcc_back.sv
rtl/registered_logic_consistency_checker.sv
rtl/rlcc_checker.sv
verif/testbench.sv
